### hdl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// Bounded composition counter package
// Shared request types, controller/datapath command and status groups, and
// count constants.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int ENTRY_W = 32;
	localparam int WIN_W   = 41;

	localparam logic [ENTRY_W-1:0] OVER_MARK   = 32'h8000_0000;
	localparam logic [30:0]        COUNT_LIMIT = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [7:0] total_units;
		logic [7:0] slot_count;
		logic [7:0] max_per_slot;
	} in_req_t;

	typedef struct packed {
		logic [30:0] way_count;
		logic        saturated;
	} out_req_t;

	typedef struct packed {
		logic load;
		logic step;
		logic row_end;
		logic fetch;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic skip_in;
		logic col_last;
		logic slot_last;
	} status_t;

endpackage

### hdl/bcc_datapath.sv
// ----------------------------------------------------------------------------
// Bounded composition counter datapath
// Holds the query, the two ping-pong row memories, the window accumulator and
// the result register. Each step reads two entries of the previous row into
// registers, and the registered step then writes one entry of the current row.
// ----------------------------------------------------------------------------
module bcc_datapath #(
	parameter int MAX_TOTAL = 255,
	parameter int MAX_SLOTS = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bcc_pkg::in_req_t  query,
	input  bcc_pkg::cmd_t     cmd,
	output bcc_pkg::status_t  status,
	output bcc_pkg::out_req_t result
);
	import bcc_pkg::*;

	localparam int DEPTH = MAX_TOTAL + 1;
	localparam int IW    = $clog2(DEPTH);
	localparam int SW    = $clog2(MAX_SLOTS + 1);
	localparam int CW    = (IW > 8) ? IW : 8;

	logic [ENTRY_W-1:0] mem_a [DEPTH];
	logic [ENTRY_W-1:0] mem_b [DEPTH];

	logic [IW-1:0] total_q;
	logic [SW-1:0] slots_q;
	logic [7:0]    maxv_q;
	logic          refused_q;
	logic          zero_total_q;

	logic          first_q;
	logic          sel_q;
	logic [IW-1:0] col_q;
	logic [SW-1:0] slot_q;
	logic [WIN_W-1:0] win_q;

	logic          v_s1;
	logic [IW-1:0] col_s1;
	logic          sub_s1;
	logic          subz_s1;
	logic          colz_s1;
	logic [ENTRY_W-1:0] rd0_a_s1, rd1_a_s1, rd0_b_s1, rd1_b_s1;

	out_req_t      result_q;

	logic          refused_in;
	logic [CW-1:0] diff;
	logic          sub_now;
	logic [IW-1:0] addr0, addr1;
	logic [ENTRY_W-1:0] prev0, prev1, add_v, sub_v, wdata;
	logic [WIN_W-1:0] win_next;
	out_req_t      cap;

	// A query beyond the table bounds is refused and answered with zero.
	assign refused_in = (32'(query.total_units) > 32'(MAX_TOTAL)) ||
		(32'(query.slot_count) > 32'(MAX_SLOTS));

	assign status.skip_in   = refused_in || (query.slot_count == 8'd0);
	assign status.col_last  = (col_q == total_q);
	assign status.slot_last = (slot_q == slots_q - SW'(1));

	assign diff    = CW'(col_q) - CW'(maxv_q) - CW'(1);
	assign sub_now = CW'(col_q) > CW'(maxv_q);
	assign addr0   = cmd.fetch ? total_q : col_q;
	assign addr1   = diff[IW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			total_q      <= IW'(query.total_units);
			slots_q      <= SW'(query.slot_count);
			maxv_q       <= query.max_per_slot;
			refused_q    <= refused_in;
			zero_total_q <= (query.total_units == 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			sel_q   <= 1'b0;
			col_q   <= '0;
			slot_q  <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= cmd.step;
			if (cmd.load) begin
				first_q <= 1'b1;
				sel_q   <= 1'b0;
				col_q   <= '0;
				slot_q  <= '0;
			end else if (cmd.row_end) begin
				first_q <= 1'b0;
				sel_q   <= ~sel_q;
				col_q   <= '0;
				slot_q  <= slot_q + SW'(1);
			end else if (cmd.step) begin
				col_q <= col_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			col_s1  <= col_q;
			sub_s1  <= sub_now;
			subz_s1 <= (diff == '0);
			colz_s1 <= (col_q == '0);
		end
	end

	// The first row is the unit row, so it is generated instead of read.
	always_comb begin
		prev0    = sel_q ? rd0_b_s1 : rd0_a_s1;
		prev1    = sel_q ? rd1_b_s1 : rd1_a_s1;
		add_v    = first_q ? ENTRY_W'(colz_s1) : prev0;
		sub_v    = '0;
		if (sub_s1) begin
			sub_v = first_q ? ENTRY_W'(subz_s1) : prev1;
		end
		win_next = win_q + WIN_W'(add_v) - WIN_W'(sub_v);
		wdata    = (win_next >= WIN_W'(OVER_MARK)) ? OVER_MARK : win_next[ENTRY_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.row_end) begin
			win_q <= '0;
		end else if (v_s1) begin
			win_q <= win_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step || cmd.fetch) begin
			rd0_a_s1 <= mem_a[addr0];
			rd1_a_s1 <= mem_a[addr1];
		end
		if (v_s1 && sel_q) begin
			mem_a[col_s1] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step || cmd.fetch) begin
			rd0_b_s1 <= mem_b[addr0];
			rd1_b_s1 <= mem_b[addr1];
		end
		if (v_s1 && !sel_q) begin
			mem_b[col_s1] <= wdata;
		end
	end

	always_comb begin
		if (first_q) begin
			cap.way_count = (refused_q || !zero_total_q) ? 31'd0 : 31'd1;
			cap.saturated = 1'b0;
		end else if (prev0[ENTRY_W-1]) begin
			cap.way_count = COUNT_LIMIT;
			cap.saturated = 1'b1;
		end else begin
			cap.way_count = prev0[30:0];
			cap.saturated = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			result_q <= cap;
		end
	end

	assign result = result_q;

	a_step_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (col_q <= total_q))
		else $error("step issued past the end of the row");

	a_fetch_after_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> $past(cmd.row_end))
		else $error("result fetch without a finished row");

	a_row_end_writes_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.row_end |-> (v_s1 && col_s1 == total_q))
		else $error("row closed before its last entry was written");

endmodule

### hdl/bcc_controller.sv
// ----------------------------------------------------------------------------
// Bounded composition counter controller
// Sequences one query through the row passes, the result fetch and the
// capture into the output register, and runs both handshakes.
// ----------------------------------------------------------------------------
module bcc_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             query_valid,
	output logic             query_stall,
	output logic             result_valid,
	input  logic             result_stall,
	input  bcc_pkg::status_t status,
	output bcc_pkg::cmd_t    cmd
);
	import bcc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_ROW     = 5'b00010,
		ST_DRAIN   = 5'b00100,
		ST_FETCH   = 5'b01000,
		ST_CAPTURE = 5'b10000
	} state_t;

	state_t state_q, state_next;
	logic   out_valid_q;
	logic   accept;

	assign query_stall  = (state_q != ST_IDLE);
	assign accept       = query_valid && (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load   = 1'b1;
					state_next = status.skip_in ? ST_CAPTURE : ST_ROW;
				end
			end
			ST_ROW: begin
				cmd.step = 1'b1;
				if (status.col_last) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.row_end = 1'b1;
				state_next  = status.slot_last ? ST_FETCH : ST_ROW;
			end
			ST_FETCH: begin
				cmd.fetch  = 1'b1;
				state_next = ST_CAPTURE;
			end
			ST_CAPTURE: begin
				// The previous result must leave the output register first.
				if (!out_valid_q || !result_stall) begin
					cmd.capture = 1'b1;
					state_next  = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_valid_from_capture: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.capture))
		else $error("result raised without a capture");

	a_capture_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> out_valid_q)
		else $error("captured result not presented");

endmodule

### hdl/bounded_composition_counter.sv
// ----------------------------------------------------------------------------
// Bounded composition counter
// Counts the ordered ways to split a total into a number of slots, each
// holding from zero up to a maximum, with a saturating 31-bit count.
// ----------------------------------------------------------------------------
// Usage:
//   A query request (total_units, slot_count, max_per_slot) is taken when
//   query_valid is high and query_stall is low. The block works on one query
//   at a time and raises query_stall until the count has been captured.
//   The result request (way_count, saturated) is held in an output register
//   with result_valid high until result_stall is low; a new query may be
//   accepted while a finished result still waits there, and its count then
//   waits in the datapath, with query_stall high, until the register frees.
//   A query with slot_count >= 1 runs one row pass per slot over table
//   entries 0 to total_units; a zero slot count or a refused query skips
//   the passes and goes straight to the capture. Each row pass moves one
//   table entry per cycle through a read-add-write loop on the row
//   memories and ends in a drain state. The next query is taken in the
//   cycle after the capture. Reset clears the controller; the row memories
//   need no clearing because every entry whose value is used is written
//   before it is read.
// ----------------------------------------------------------------------------
module bounded_composition_counter #(
	parameter int MAX_TOTAL = 255,
	parameter int MAX_SLOTS = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query_valid,
	output logic              query_stall,
	input  bcc_pkg::in_req_t  query,
	output logic              result_valid,
	input  logic              result_stall,
	output bcc_pkg::out_req_t result
);
	import bcc_pkg::*;

	cmd_t    cmd;
	status_t status;

	bcc_controller u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	bcc_datapath #(
		.MAX_TOTAL (MAX_TOTAL),
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

### tb/tb_bounded_composition_counter.sv
// ----------------------------------------------------------------------------
// Bounded composition counter testbench
// Sends query requests through the valid/stall channel and predicts each
// count with a row-by-row window-sum table of its own. Every result request is
// compared field by field with the oldest outstanding prediction. Random idle
// bursts on both sides, one long result hold-off, and one drain pause are
// mixed in.
// ----------------------------------------------------------------------------
module tb_bounded_composition_counter;
	timeunit 1ns;
	timeprecision 1ps;
	import bcc_pkg::*;

	localparam int CYCLE_LIMIT   = 4_000_000;
	localparam int RANDOM_ITEMS  = 100;
	localparam int QUIET_TAIL    = 20;
	localparam int HOLD_CYCLES   = 8000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_AT       = 30;
	localparam int DRAIN_AT      = 60;

	class composition_board;
		out_req_t awaited_counts[$];
		int mismatch_count;

		function new();
			mismatch_count = 0;
		endfunction

		// Rows hold min(true count, 2^31); 2^31 marks an overflowed entry.
		function out_req_t count_ways(in_req_t q);
			logic [31:0] last_row [0:255];
			logic [31:0] next_row [0:255];
			longint window;
			out_req_t ways;
			int s;
			int j;
			for (j = 0; j < 256; j++) begin
				last_row[j] = '0;
				next_row[j] = '0;
			end
			last_row[0] = 32'd1;
			for (s = 0; s < int'(q.slot_count); s++) begin
				window = 0;
				for (j = 0; j <= int'(q.total_units); j++) begin
					window += longint'(last_row[j]);
					if (j > int'(q.max_per_slot))
						window -= longint'(last_row[j - int'(q.max_per_slot) - 1]);
					next_row[j] = (window >= longint'(OVER_MARK)) ? OVER_MARK : window[31:0];
				end
				for (j = 0; j <= int'(q.total_units); j++)
					last_row[j] = next_row[j];
			end
			if (last_row[q.total_units] >= OVER_MARK) begin
				ways.way_count = COUNT_LIMIT;
				ways.saturated = 1'b1;
			end else begin
				ways.way_count = last_row[q.total_units][30:0];
				ways.saturated = 1'b0;
			end
			return ways;
		endfunction

		function void note_query(in_req_t q);
			awaited_counts.push_back(count_ways(q));
		endfunction

		function void check_result(out_req_t got);
			out_req_t want;
			if (awaited_counts.size() == 0) begin
				$error("result with no query outstanding: way_count %0d, saturated %0d",
					got.way_count, got.saturated);
				mismatch_count++;
				return;
			end
			want = awaited_counts.pop_front();
			if (got.way_count !== want.way_count) begin
				$error("way_count: expected %0d, actual %0d", want.way_count, got.way_count);
				mismatch_count++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0d, actual %0d", want.saturated, got.saturated);
				mismatch_count++;
			end
		endfunction

		function int pending();
			return awaited_counts.size();
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     query_valid = 1'b0;
	logic     query_stall;
	in_req_t  query = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	out_req_t result;

	composition_board board = new();
	int  cycle_count = 0;
	int  gap_pct = 0;
	bit  quiet = 1'b0;
	bit  hold_off_req = 1'b0;

	bounded_composition_counter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.query        (query),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(posedge clk) begin
		if (arst_n && query_valid && !query_stall)
			board.note_query(query);
		if (arst_n && result_valid && !result_stall)
			board.check_result(result);
	end

	function automatic in_req_t make_req(int total, int slots, int most);
		in_req_t q;
		q.total_units  = 8'(total);
		q.slot_count   = 8'(slots);
		q.max_per_slot = 8'(most);
		return q;
	endfunction

	// Run time grows with slots times total, so wide totals go with few slots
	// and many slots with small totals; one band sits where counts saturate.
	function automatic in_req_t random_query();
		int mode;
		int total;
		int slots;
		int most;
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			total = $urandom_range(0, 15);
			slots = $urandom_range(0, 15);
		end else if (mode == 6) begin
			total = $urandom_range(0, 255);
			slots = $urandom_range(0, 3);
		end else if (mode == 7) begin
			total = $urandom_range(0, 7);
			slots = $urandom_range(0, 255);
		end else begin
			total = $urandom_range(20, 40);
			slots = $urandom_range(15, 40);
		end
		if ($urandom_range(0, 1) == 1)
			most = $urandom_range(0, 255);
		else
			most = $urandom_range(0, (total + 1 > 255) ? 255 : total + 1);
		return make_req(total, slots, most);
	endfunction

	task automatic send_query(in_req_t q);
		query       <= q;
		query_valid <= 1'b1;
		do @(posedge clk); while (query_stall);
	endtask

	task automatic random_gap();
		if (!quiet && $urandom_range(1, 100) <= gap_pct) begin
			query_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Result side: random stall bursts, plus one long hold-off on request so
	// that the block finishes a query, takes another and then stalls its input.
	initial begin
		int stall_pct;
		int phase_left;
		stall_pct  = 0;
		phase_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
				hold_off_req = 1'b0;
			end else if (!quiet && $urandom_range(1, 100) <= stall_pct) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				result_stall <= 1'b0;
			end
			if (phase_left == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 40;
				endcase
				phase_left = 64;
			end else begin
				phase_left--;
			end
		end
	end

	initial begin
		in_req_t plan[$];
		int idx;

		plan.push_back(make_req(0, 0, 0));       // zero slots, zero total
		plan.push_back(make_req(5, 0, 3));       // zero slots, nonzero total
		plan.push_back(make_req(255, 0, 255));
		plan.push_back(make_req(0, 5, 0));       // zero maximum, zero total
		plan.push_back(make_req(3, 2, 0));       // zero maximum, unreachable total
		plan.push_back(make_req(3, 2, 10));      // maximum above the total
		plan.push_back(make_req(0, 255, 0));
		plan.push_back(make_req(255, 1, 255));
		plan.push_back(make_req(255, 1, 254));
		plan.push_back(make_req(10, 4, 3));
		plan.push_back(make_req(200, 3, 100));
		plan.push_back(make_req(60, 30, 60));    // saturates
		plan.push_back(make_req(170, 85, 170));
		plan.push_back(make_req(128, 128, 128));
		plan.push_back(make_req(254, 255, 1));
		plan.push_back(make_req(255, 255, 1));
		plan.push_back(make_req(255, 255, 0));
		plan.push_back(make_req(255, 255, 255)); // largest table, saturates

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 30;
		foreach (plan[i]) begin
			random_gap();
			send_query(plan[i]);
		end

		for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
			if (idx % 16 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 25;
					default: gap_pct = 50;
				endcase
			end
			if (idx == RANDOM_ITEMS - QUIET_TAIL)
				quiet = 1'b1;
			if (idx == HOLD_AT)
				hold_off_req = 1'b1;
			if (idx == DRAIN_AT) begin
				query_valid <= 1'b0;
				do @(posedge clk); while (board.pending() != 0);
			end
			if (!hold_off_req)
				random_gap();
			send_query(random_query());
		end

		query_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatch_count == 0 && board.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
